>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the keypad repeat block.
// No dependencies; include after the timescale line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define KRC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define KRC_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

>>> sv/krc_pkg.sv
// Package for the keypad repeat / short press / reset combo block.
// Holds action codes, key bit positions, counter limits and register indexes.
`timescale 1ns / 1ps

package krc_pkg;

    localparam int ACT_W      = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_FRAME        = 2'd0,
        ACT_LATCH        = 2'd1,
        ACT_RESET_REPEAT = 2'd2,
        ACT_UNPRESS      = 2'd3
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_CONFIRM = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_LIMIT   = 1'd1;

    localparam int CONFIRM_W = 8;
    localparam int LIMIT_W   = 7;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd4;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 7'd12;

    // Key bit positions
    localparam int KEY_A      = 0;
    localparam int KEY_B      = 1;
    localparam int KEY_SELECT = 2;
    localparam int KEY_START  = 3;
    localparam int DPAD_LO    = 4;
    localparam int DPAD_W     = 4;
    localparam int KEY_R      = 8;
    localparam int COMBO_W    = 4;

    // Buffer / visible register rows
    localparam int ROWS         = 4;
    localparam int ROW_HELD     = 0;
    localparam int ROW_PRESSED  = 1;
    localparam int ROW_REPEATED = 2;
    localparam int ROW_SHORT    = 3;

    // Auto-repeat counter
    localparam int REP_W = 6;
    localparam logic [REP_W-1:0] REPEAT_ONE    = 6'd1;
    localparam logic [REP_W-1:0] REPEAT_MAX    = 6'd50;
    localparam logic [REP_W-1:0] REPEAT_FIRE   = 6'd48;
    localparam logic [REP_W-1:0] REPEAT_RELOAD = 6'd43;

    // Hold timers
    localparam int HOLD_W = 10;
    localparam logic [HOLD_W-1:0] HOLD_ONE    = 10'd1;
    localparam logic [HOLD_W-1:0] HOLD_MAX    = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_FORCED = 10'd999;

    // Combo counter
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] COMBO_MAX = 8'd255;

endpackage

>>> sv/krc_reg_slice.sv
// Single-entry register slice with valid/ready flow control.
// Standalone; used on the request side and on the result side of the block.
`timescale 1ns / 1ps

module krc_reg_slice #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;

    // take a new entry when empty or when the held one leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule

>>> sv/krc_frame.sv
// Frame logic: key edges, d-pad auto-repeat, B/R hold timers, buffers, reset combo.
// Depends on krc_pkg. Updates state on each taken request, drives the packed result.
`timescale 1ns / 1ps

module krc_frame #(
    parameter int KEY_BITS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [krc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [krc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  take,
    input  krc_pkg::action_t                      action,
    input  logic [KEY_BITS-1:0]                   keys,
    output logic [8*KEY_BITS:0]                   res_data
);

    import krc_pkg::*;

    logic [CONFIRM_W-1:0] confirm_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic [KEY_BITS-1:0] prev_reg, prev_next;
    logic [KEY_BITS-1:0] pressed_reg, pressed_next;
    logic [KEY_BITS-1:0] repeated_reg, repeated_next;
    logic [DPAD_W-1:0]   dpad_reg, dpad_next;
    logic [REP_W-1:0]    rep_cnt_reg, rep_cnt_next;
    logic [HOLD_W-1:0]   hold_b_reg, hold_b_next;
    logic [HOLD_W-1:0]   hold_r_reg, hold_r_next;
    logic [CNT_W-1:0]    combo_reg, combo_next;
    logic [KEY_BITS-1:0] buf_reg [ROWS];
    logic [KEY_BITS-1:0] buf_next [ROWS];
    logic [KEY_BITS-1:0] vis_reg [ROWS];
    logic [KEY_BITS-1:0] vis_next [ROWS];

    logic [KEY_BITS-1:0] pressed;
    logic [DPAD_W-1:0]   dpad;
    logic [KEY_BITS-1:0] rep_bits;
    logic [KEY_BITS-1:0] short_bits;
    logic                pulse;
    logic [HOLD_W-1:0]   limit_ext;
    logic [CNT_W-1:0]    combo_inc;

    assign pressed   = ~prev_reg & keys;
    assign dpad      = keys[DPAD_LO +: DPAD_W];
    assign limit_ext = {{(HOLD_W-LIMIT_W){1'b0}}, limit_reg};
    assign combo_inc = combo_reg + 1'b1;

    always_comb begin
        prev_next     = prev_reg;
        pressed_next  = pressed_reg;
        repeated_next = repeated_reg;
        dpad_next     = dpad_reg;
        rep_cnt_next  = rep_cnt_reg;
        hold_b_next   = hold_b_reg;
        hold_r_next   = hold_r_reg;
        combo_next    = combo_reg;
        buf_next      = buf_reg;
        vis_next      = vis_reg;
        rep_bits      = '0;
        short_bits    = '0;
        pulse         = 1'b0;

        case (action)
            ACT_FRAME: begin
                // d-pad auto-repeat: restart on a direction change, clear when no key is held
                if (|keys) begin
                    if (dpad_reg == dpad) begin
                        if (rep_cnt_reg < REPEAT_MAX) begin
                            rep_cnt_next = rep_cnt_reg + 1'b1;
                        end
                    end else begin
                        dpad_next    = dpad;
                        rep_cnt_next = REPEAT_ONE;
                    end
                end else begin
                    dpad_next    = '0;
                    rep_cnt_next = '0;
                end
                if (rep_cnt_next == REPEAT_ONE || rep_cnt_next == REPEAT_FIRE) begin
                    rep_bits                     = pressed;
                    rep_bits[DPAD_LO +: DPAD_W]  = rep_bits[DPAD_LO +: DPAD_W] | dpad_next;
                end
                if (rep_cnt_next == REPEAT_FIRE) begin
                    rep_cnt_next = REPEAT_RELOAD;
                end

                // hold timers: flag a short release, then clear
                if (keys[KEY_B]) begin
                    if (hold_b_reg < HOLD_MAX) begin
                        hold_b_next = hold_b_reg + 1'b1;
                    end
                end else begin
                    short_bits[KEY_B] = (hold_b_reg > HOLD_ONE) && (hold_b_reg < limit_ext);
                    hold_b_next       = '0;
                end
                if (keys[KEY_R]) begin
                    if (hold_r_reg < HOLD_MAX) begin
                        hold_r_next = hold_r_reg + 1'b1;
                    end
                end else begin
                    short_bits[KEY_R] = (hold_r_reg > HOLD_ONE) && (hold_r_reg < limit_ext);
                    hold_r_next       = '0;
                end

                prev_next     = keys;
                pressed_next  = pressed;
                repeated_next = rep_bits;

                buf_next[ROW_HELD]     = buf_reg[ROW_HELD] | keys;
                buf_next[ROW_PRESSED]  = buf_reg[ROW_PRESSED] | pressed;
                buf_next[ROW_REPEATED] = buf_reg[ROW_REPEATED] | rep_bits;
                buf_next[ROW_SHORT]    = buf_reg[ROW_SHORT] | short_bits;

                // reset combo: pulse once when the count steps onto the confirm value
                if (&keys[COMBO_W-1:0]) begin
                    if (combo_reg < COMBO_MAX) begin
                        combo_next = combo_inc;
                        pulse      = (confirm_reg != '0) && (combo_inc == confirm_reg);
                    end
                end else begin
                    combo_next = '0;
                end
            end
            ACT_LATCH: begin
                vis_next = buf_reg;
                for (int r = 0; r < ROWS; r++) begin
                    buf_next[r] = '0;
                end
            end
            ACT_RESET_REPEAT: begin
                vis_next[ROW_REPEATED] = '0;
                rep_cnt_next           = '0;
                dpad_next              = '0;
                hold_b_next            = HOLD_FORCED;
                hold_r_next            = HOLD_FORCED;
            end
            ACT_UNPRESS: begin
                vis_next[ROW_PRESSED] = '0;
                buf_next[ROW_PRESSED] = '0;
                pressed_next          = '0;
            end
            default: begin
                pulse = 1'b0;
            end
        endcase
    end

    assign res_data = {pulse,
                       vis_next[ROW_SHORT], vis_next[ROW_REPEATED],
                       vis_next[ROW_PRESSED], vis_next[ROW_HELD],
                       short_bits, repeated_next, pressed_next, prev_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg <= CONFIRM_RESET;
            limit_reg   <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RESET_CONFIRM: confirm_reg <= cfg_wdata[CONFIRM_W-1:0];
                CFG_SHORT_LIMIT:   limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                default:           limit_reg   <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            pressed_reg  <= '0;
            repeated_reg <= '0;
            dpad_reg     <= '0;
            rep_cnt_reg  <= '0;
            hold_b_reg   <= '0;
            hold_r_reg   <= '0;
            combo_reg    <= '0;
            for (int r = 0; r < ROWS; r++) begin
                buf_reg[r] <= '0;
                vis_reg[r] <= '0;
            end
        end else if (take) begin
            prev_reg     <= prev_next;
            pressed_reg  <= pressed_next;
            repeated_reg <= repeated_next;
            dpad_reg     <= dpad_next;
            rep_cnt_reg  <= rep_cnt_next;
            hold_b_reg   <= hold_b_next;
            hold_r_reg   <= hold_r_next;
            combo_reg    <= combo_next;
            buf_reg      <= buf_next;
            vis_reg      <= vis_next;
        end
    end

endmodule

>>> sv/keypad_repeat_short_press_combo.sv
// Top level of the keypad auto-repeat / short press / reset combo block.
// Depends on krc_pkg, krc_reg_slice and krc_frame.
`timescale 1ns / 1ps

// Each request is one key frame or one control action; each gives exactly one
// result. A request is captured in an input register, its state update and
// result are formed in one pass of short logic, and the result is held in an
// output register. Throughput is one request per clock cycle while m_tready is
// high; m_tvalid rises after the request passes the input register and then the
// output register. The output register frees the input side,
// so one more request is taken while an earlier result still waits for m_tready.
// Frames update the held/pressed edges, the d-pad repeat counter (fires on the
// first frame, at count 48, then every 5 frames), the B and R hold timers
// (short press on release after 2 to short_press_limit-1 frames) and the
// A+B+Select+Start combo counter, which pulses soft_reset once when it reaches
// reset_confirm_frames. Write configuration only while no request is in flight.
// There is no clearing pass: all state is set by the synchronous reset.
module keypad_repeat_short_press_combo #(
    parameter int KEY_BITS = 10
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration: index 0 reset_confirm_frames, index 1 short_press_limit
    input  logic                                       cfg_we,
    input  logic [krc_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [krc_pkg::CFG_DATA_W-1:0]             cfg_wdata,
    // request channel
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // tdata from bit 0: action, raw_keys, zero fill
    input  logic [((krc_pkg::ACT_W+KEY_BITS+7)/8)*8-1:0] s_tdata,
    // result channel
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // tdata from bit 0: cur_held, cur_pressed, cur_repeated, cur_short_press,
    // latched_held, latched_pressed, latched_repeated, latched_short_press,
    // soft_reset, zero fill
    output logic [((8*KEY_BITS+1+7)/8)*8-1:0]          m_tdata
);

    import krc_pkg::*;

    localparam int IN_W      = ACT_W + KEY_BITS;
    localparam int RES_W     = 8*KEY_BITS + 1;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    logic                 req_valid;
    logic                 req_ready;
    logic [IN_W-1:0]      req_data;
    logic [RES_W-1:0]     res_data;
    logic [RES_W-1:0]     res_out;
    action_t              req_action;

    // hold the incoming request
    krc_reg_slice #(
        .DATA_W (IN_W)
    ) u_in_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IN_W-1:0]),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .out_data  (req_data)
    );

    assign req_action = action_t'(req_data[ACT_W-1:0]);

    // advance state only when the result has a place to go
    krc_frame #(
        .KEY_BITS (KEY_BITS)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .take      (req_valid && req_ready),
        .action    (req_action),
        .keys      (req_data[IN_W-1:ACT_W]),
        .res_data  (res_data)
    );

    // hold the result until the consumer takes it
    krc_reg_slice #(
        .DATA_W (RES_W)
    ) u_out_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {{(M_TDATA_W-RES_W){1'b0}}, res_out};

endmodule

>>> sv/krc_checker.sv
// Port-level checker for the keypad repeat block, bound to the top level.
// Depends on krc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krc_checker #(
    parameter int KEY_BITS = 10
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((8*KEY_BITS+1+7)/8)*8-1:0]    m_tdata
);

    import krc_pkg::*;

    logic [KEY_BITS-1:0] cur_held;
    logic [KEY_BITS-1:0] cur_pressed;
    logic [KEY_BITS-1:0] cur_short;
    logic [KEY_BITS-1:0] lat_short;
    logic [KEY_BITS-1:0] short_mask;
    logic                soft_reset;

    assign cur_held    = m_tdata[0*KEY_BITS +: KEY_BITS];
    assign cur_pressed = m_tdata[1*KEY_BITS +: KEY_BITS];
    assign cur_short   = m_tdata[3*KEY_BITS +: KEY_BITS];
    assign lat_short   = m_tdata[7*KEY_BITS +: KEY_BITS];
    assign soft_reset  = m_tdata[8*KEY_BITS];

    always_comb begin
        short_mask        = '0;
        short_mask[KEY_B] = 1'b1;
        short_mask[KEY_R] = 1'b1;
    end

    // a stalled result stays offered
    `KRC_ASSERT(a_res_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    // new presses are always among the held keys
    `KRC_NEVER(a_press_held, aclk, aresetn, m_tvalid && ((cur_pressed & ~cur_held) != '0), "press not held")
    // short press flags come from B and R only
    `KRC_NEVER(a_short_br, aclk, aresetn, m_tvalid && (((cur_short | lat_short) & ~short_mask) != '0), "short press off B/R")
    // the reset pulse needs the full combo held
    `KRC_ASSERT(a_pulse_combo, aclk, aresetn, m_tvalid && soft_reset |-> (&cur_held[COMBO_W-1:0]), "pulse without combo")

endmodule

bind keypad_repeat_short_press_combo krc_checker #(
    .KEY_BITS (KEY_BITS)
) u_krc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
